// File: hdl/wpb_pkg.sv
// Package for the weighted pixel blender.
// Holds the controller state type, command and status structs and fixed field widths.
// No dependencies.
package wpb_pkg;

  localparam int unsigned COLOUR_W     = 8;
  localparam int unsigned WEIGHT_W     = 24;
  localparam int unsigned QUO_W        = 8;
  localparam int unsigned STEP_W       = 3;
  localparam logic [COLOUR_W-1:0] ALPHA_THRESH = 8'd127;
  localparam logic [COLOUR_W-1:0] ALPHA_FULL   = 8'd255;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_LOAD,
    S_DIV,
    S_FIN
  } wpb_state_t;

  typedef struct packed {
    logic load_in;
    logic acc;
    logic div_load;
    logic div_step;
    logic out_load;
  } wpb_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
  } wpb_stat_t;

endpackage

// File: hdl/wpb_if.sv
// Handshake channel interfaces of the weighted pixel blender.
// Depends on wpb_pkg for field widths.
interface wpb_in_if;
  import wpb_pkg::*;
  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] blue;
  logic [COLOUR_W-1:0] green;
  logic [COLOUR_W-1:0] red;
  logic [COLOUR_W-1:0] alpha;
  logic [WEIGHT_W-1:0] weight;
  logic                covered;
  logic                last_contribution;
  modport source (output valid, blue, green, red, alpha, weight, covered, last_contribution,
                  input ready);
  modport sink   (input valid, blue, green, red, alpha, weight, covered, last_contribution,
                  output ready);
endinterface

interface wpb_out_if;
  import wpb_pkg::*;
  logic                valid;
  logic                ready;
  logic [COLOUR_W-1:0] out_blue;
  logic [COLOUR_W-1:0] out_green;
  logic [COLOUR_W-1:0] out_red;
  logic [COLOUR_W-1:0] out_alpha;
  modport source (output valid, out_blue, out_green, out_red, out_alpha, input ready);
  modport sink   (input valid, out_blue, out_green, out_red, out_alpha, output ready);
endinterface

interface wpb_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/wpb_dp.sv
// Datapath of the weighted pixel blender: multipliers, saturating sums, divider lanes, output register.
// Depends on wpb_pkg; driven by wpb_ctrl commands.
module wpb_dp #(
  parameter int unsigned MAX_IMAGES  = 8,
  parameter int unsigned WEIGHT_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  wpb_pkg::wpb_cmd_t            cmd,
  output wpb_pkg::wpb_stat_t           stat,
  input  logic                         cfg_we,
  input  logic                         cfg_data,
  input  logic [wpb_pkg::COLOUR_W-1:0] blue,
  input  logic [wpb_pkg::COLOUR_W-1:0] green,
  input  logic [wpb_pkg::COLOUR_W-1:0] red,
  input  logic [wpb_pkg::COLOUR_W-1:0] alpha,
  input  logic [wpb_pkg::WEIGHT_W-1:0] weight,
  input  logic                         covered,
  input  logic                         last_contribution,
  output logic [wpb_pkg::COLOUR_W-1:0] out_blue,
  output logic [wpb_pkg::COLOUR_W-1:0] out_green,
  output logic [wpb_pkg::COLOUR_W-1:0] out_red,
  output logic [wpb_pkg::COLOUR_W-1:0] out_alpha
);
  import wpb_pkg::*;

  localparam int unsigned EW = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
  localparam longint unsigned WMAX = (64'd1 << WEIGHT_BITS) - 64'd1;
  localparam longint unsigned WCAP = longint'(MAX_IMAGES) * WMAX;
  localparam longint unsigned CCAP = 64'd255 * WCAP;
  localparam int unsigned SW = $clog2(WCAP + 64'd1);
  localparam int unsigned CW = $clog2(CCAP + 64'd1);
  localparam int unsigned PW = EW + COLOUR_W;
  localparam int unsigned DW = CW + 2;
  localparam logic [SW:0] WCAP_V = (SW+1)'(WCAP);
  localparam logic [CW:0] CCAP_V = (CW+1)'(CCAP);

  logic                       mask_mode;
  logic [2:0][PW-1:0]         prod;
  logic [EW-1:0]              wadd;
  logic                       last_q;
  logic [2:0][CW-1:0]         sum_c;
  logic [SW-1:0]              sum_w;
  logic [2:0][DW-1:0]         rem;
  logic [DW-1:0]              dsh;
  logic [2:0][QUO_W-1:0]      quo;
  logic                       wzero;
  logic [STEP_W-1:0]          step;

  logic [EW-1:0]              eff;
  logic                       take;
  logic [2:0][COLOUR_W-1:0]   colour;
  logic [2:0][CW:0]           csum;
  logic [SW:0]                wsum;

  always_comb begin
    colour = {red, green, blue};
    if (mask_mode) begin
      eff  = EW'(1);
      take = covered && (alpha > ALPHA_THRESH);
    end else begin
      eff  = weight[EW-1:0];
      take = covered;
    end
    for (int i = 0; i < 3; i++) begin
      csum[i] = {1'b0, sum_c[i]} + (CW+1)'(prod[i]);
    end
    wsum = {1'b0, sum_w} + (SW+1)'(wadd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_mode <= 1'b0;
    end else if (cfg_we) begin
      mask_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      last_q <= last_contribution;
      wadd   <= take ? eff : '0;
      for (int i = 0; i < 3; i++) begin
        prod[i] <= take ? ({{(PW-EW){1'b0}}, eff} * {{EW{1'b0}}, colour[i]}) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_c <= '0;
      sum_w <= '0;
    end else if (cmd.div_load) begin
      sum_c <= '0;
      sum_w <= '0;
    end else if (cmd.acc) begin
      for (int i = 0; i < 3; i++) begin
        sum_c[i] <= (csum[i] > CCAP_V) ? CCAP_V[CW-1:0] : csum[i][CW-1:0];
      end
      sum_w <= (wsum > WCAP_V) ? WCAP_V[SW-1:0] : wsum[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dsh   <= DW'({sum_w, 1'b0}) << (QUO_W - 1);
      wzero <= (sum_w == '0);
      step  <= STEP_W'(QUO_W - 1);
      quo   <= '0;
      for (int i = 0; i < 3; i++) begin
        rem[i] <= DW'({sum_c[i], 1'b0}) + DW'(sum_w);
      end
    end else if (cmd.div_step) begin
      dsh  <= dsh >> 1;
      step <= step - STEP_W'(1);
      for (int i = 0; i < 3; i++) begin
        if (rem[i] >= dsh) begin
          rem[i] <= rem[i] - dsh;
          quo[i] <= {quo[i][QUO_W-2:0], 1'b1};
        end else begin
          quo[i] <= {quo[i][QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_blue  <= wzero ? '0 : quo[0];
      out_green <= wzero ? '0 : quo[1];
      out_red   <= wzero ? '0 : quo[2];
      out_alpha <= wzero ? '0 : ALPHA_FULL;
    end
  end

  assign stat.last     = last_q;
  assign stat.div_done = (step == '0);

endmodule

// File: hdl/wpb_ctrl.sv
// Controller of the weighted pixel blender: handshakes and sequencing of accumulate and divide.
// Depends on wpb_pkg; drives wpb_dp through the command struct.
module wpb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  wpb_pkg::wpb_stat_t stat,
  output wpb_pkg::wpb_cmd_t  cmd
);
  import wpb_pkg::*;

  wpb_state_t state;
  wpb_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = stat.last ? S_LOAD : S_IDLE;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result beat overwritten before delivery");

  a_accept_then_acc: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_ACC))
    else $error("accepted beat not accumulated");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && stat.div_done) |=> (state == S_FIN))
    else $error("divider did not finish");

  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("result valid without load");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule

// File: hdl/weighted_pixel_blend_top.sv
// Top level of the weighted pixel blender: input, result and register channels.
// Depends on wpb_pkg, wpb_if, wpb_ctrl and wpb_dp.
//
// A contribution that does not close a pixel occupies the block while it takes the beat and
// forms the three weight-times-colour products, then while it adds them into the saturating
// sums. A closing contribution goes through the same steps, then moves the sums into the
// divider and clears them, runs the divider steps in which the three restoring-division lanes
// produce one quotient bit each per step, and loads the output register.
// The result register holds one finished pixel, so input is taken again while it waits; a
// second finished pixel waits in the divider until the first has been taken. mask_mode may be
// written on the register channel at any time the block is idle.
module weighted_pixel_blend_top #(
  parameter int unsigned MAX_IMAGES  = 8,
  parameter int unsigned WEIGHT_BITS = 24
) (
  input  logic            clk,
  input  logic            rst,
  wpb_in_if.sink          pixel_in,
  wpb_out_if.source       pixel_out,
  wpb_cfg_if.sink         cfg
);
  import wpb_pkg::*;

  wpb_cmd_t  cmd;
  wpb_stat_t stat;

  assign cfg.ready = 1'b1;

  wpb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_in.valid),
    .in_ready  (pixel_in.ready),
    .out_valid (pixel_out.valid),
    .out_ready (pixel_out.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wpb_dp #(
    .MAX_IMAGES  (MAX_IMAGES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_we            (cfg.valid && cfg.ready),
    .cfg_data          (cfg.data),
    .blue              (pixel_in.blue),
    .green             (pixel_in.green),
    .red               (pixel_in.red),
    .alpha             (pixel_in.alpha),
    .weight            (pixel_in.weight),
    .covered           (pixel_in.covered),
    .last_contribution (pixel_in.last_contribution),
    .out_blue          (pixel_out.out_blue),
    .out_green         (pixel_out.out_green),
    .out_red           (pixel_out.out_red),
    .out_alpha         (pixel_out.out_alpha)
  );

endmodule
